[rtl/core/sfp_pkg.sv]
// ----------------------------------------------------------------------------
// sfp_pkg
// shared types, sizes and constant tables of the two-axis sliding spectrum
// engine: item structs, memory port structs, fixed-point helpers, and the hann
// and twiddle tables built at elaboration from one integer cos/sin recipe
// ----------------------------------------------------------------------------
package sfp_pkg;

  // sizes
  localparam int WINDOW_LEN  = 512;
  localparam int HOP_LEN     = 128;
  localparam int SAMPLE_BITS = 16;
  localparam int HALF_LEN    = WINDOW_LEN / 2;
  localparam int LOG2_LEN    = $clog2(WINDOW_LEN);
  localparam int ADDR_W      = LOG2_LEN;
  localparam int HALF_AW     = LOG2_LEN - 1;
  localparam int FILL_W      = LOG2_LEN + 1;
  localparam int STG_W       = $clog2(LOG2_LEN);
  localparam int HOP_W       = $clog2(HOP_LEN + 1);
  localparam int D           = SAMPLE_BITS;
  localparam int COEF_W      = 17;
  localparam int MUL_W       = D + COEF_W + 1;
  localparam int SQ_W        = 2 * (D + 1);
  localparam int ACC_W       = 2 * D + 20;
  localparam int IN_W        = 16;
  localparam int BIN_W       = 8;
  localparam int CNT_W       = 16;
  localparam int POW_W       = 32;

  // opcodes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_READ = 1'b1;

  // item payloads
  typedef struct packed {
    logic [0:0]             opcode;
    logic signed [IN_W-1:0] x_sample;
    logic signed [IN_W-1:0] z_sample;
    logic [BIN_W-1:0]       bin_index;
  } in_item_t;

  typedef struct packed {
    logic              frame_ready;
    logic [CNT_W-1:0]  frame_count;
    logic [BIN_W-1:0]  read_bin;
    logic [POW_W-1:0]  power_x;
    logic [POW_W-1:0]  power_z;
  } out_item_t;

  // one complex value: x / real, z / imaginary
  typedef struct packed {
    logic signed [D-1:0] re;
    logic signed [D-1:0] im;
  } sample_pair_t;

  typedef struct packed {
    logic [POW_W-1:0] px;
    logic [POW_W-1:0] pz;
  } spec_word_t;

  // engine control and memory ports between top and engine
  typedef struct packed {
    logic              start;
    logic [ADDR_W-1:0] base;
    logic [FILL_W-1:0] fill;
  } eng_req_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } win_rd_t;

  typedef struct packed {
    logic               en;
    logic [HALF_AW-1:0] addr;
    spec_word_t         data;
  } spec_wr_t;

  typedef struct packed {
    logic signed [63:0] c;
    logic signed [63:0] s;
  } cs_t;

  typedef logic [COEF_W-1:0]        hann_tab_t [WINDOW_LEN];
  typedef logic signed [COEF_W-1:0] tw_tab_t [HALF_LEN];

  localparam logic [63:0] PI_Q30  = 64'hC90F_DAA2;
  localparam logic [63:0] ONE_Q30 = 64'h4000_0000;

  // floor((v + 2^(s-1)) / 2^s)
  function automatic logic signed [ACC_W-1:0] rshr(input logic signed [ACC_W-1:0] v,
                                                   input int s);
    logic signed [ACC_W-1:0] h;
    logic signed [ACC_W-1:0] t;
    h = ACC_W'(1) << (s - 1);
    t = v + h;
    return t >>> s;
  endfunction

  // clamp to the data path width
  function automatic logic signed [D-1:0] sat_d(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = (ACC_W'(1) << (D - 1)) - ACC_W'(1);
    lo = -hi - ACC_W'(1);
    if (v > hi) return hi[D-1:0];
    else if (v < lo) return lo[D-1:0];
    else return v[D-1:0];
  endfunction

  // address bit reversal over the window length
  function automatic logic [ADDR_W-1:0] bit_rev(input logic [ADDR_W-1:0] v);
    logic [ADDR_W-1:0] r;
    for (int k = 0; k < ADDR_W; k++) begin
      r[ADDR_W-1-k] = v[k];
    end
    return r;
  endfunction

  // q30 taylor series for cos and sin of an angle up to pi/4
  function automatic cs_t taylor(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] r;
    cs_t o;
    x2 = (x * x) >> 30;
    t = x; r = x;
    t = ((t * x2) >> 30) / 64'd6;  r = r - t;
    t = ((t * x2) >> 30) / 64'd20; r = r + t;
    t = ((t * x2) >> 30) / 64'd42; r = r - t;
    t = ((t * x2) >> 30) / 64'd72; r = r + t;
    o.s = r;
    t = ONE_Q30; r = t;
    t = ((t * x2) >> 30) / 64'd2;  r = r - t;
    t = ((t * x2) >> 30) / 64'd12; r = r + t;
    t = ((t * x2) >> 30) / 64'd30; r = r - t;
    t = ((t * x2) >> 30) / 64'd56; r = r + t;
    o.c = r;
    return o;
  endfunction

  // cos and sin of a q32 fraction of a turn, q30
  function automatic cs_t turn_cos_sin(input logic [31:0] p);
    logic [63:0] f;
    logic [63:0] ang;
    logic signed [63:0] c0;
    logic signed [63:0] s0;
    cs_t t;
    cs_t r;
    f = {34'd0, p[29:0]};
    if (f <= 64'h2000_0000) begin
      ang = (f * PI_Q30) >> 31;
      t = taylor(ang);
      c0 = t.c; s0 = t.s;
    end else begin
      ang = ((64'h4000_0000 - f) * PI_Q30) >> 31;
      t = taylor(ang);
      c0 = t.s; s0 = t.c;
    end
    case (p[31:30])
      2'd0:    begin r.c = c0;  r.s = s0;  end
      2'd1:    begin r.c = -s0; r.s = c0;  end
      2'd2:    begin r.c = -c0; r.s = -s0; end
      default: begin r.c = s0;  r.s = -c0; end
    endcase
    return r;
  endfunction

  function automatic hann_tab_t make_hann();
    hann_tab_t tab;
    logic [63:0] num;
    logic [63:0] h;
    cs_t cs;
    for (int i = 0; i < WINDOW_LEN; i++) begin
      num = 64'(i) << 32;
      cs  = turn_cos_sin(32'(num / 64'(WINDOW_LEN - 1)));
      h   = (ONE_Q30 - cs.c + 64'd32768) >> 16;
      tab[i] = h[COEF_W-1:0];
    end
    return tab;
  endfunction

  function automatic tw_tab_t make_tw(input logic use_sin);
    tw_tab_t tab;
    logic signed [63:0] v;
    cs_t cs;
    for (int i = 0; i < HALF_LEN; i++) begin
      cs = turn_cos_sin(32'((64'(i) << 32) >> LOG2_LEN));
      v  = use_sin ? cs.s : cs.c;
      v  = (v + 64'sd16384) >>> 15;
      tab[i] = v[COEF_W-1:0];
    end
    return tab;
  endfunction

  localparam hann_tab_t HANN_ROM = make_hann();
  localparam tw_tab_t   TW_COS   = make_tw(1'b0);
  localparam tw_tab_t   TW_SIN   = make_tw(1'b1);

endpackage

[rtl/core/sliding_fft_two_axis_power.sv]
// ----------------------------------------------------------------------------
// sliding_fft_two_axis_power
// two-axis sliding spectrum engine: push transfers fill a circular sample
// window, every hop runs one windowed fft frame, read transfers return one
// stored power bin pair
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid, in_stall | in_data   (opcode, samples, bin)
//  out_    | output    | out_valid,out_stall| out_data  (frame flag, count, powers)
//
//  a push or read result passes through the result registers and the done
//  state into out_data; no new transfer is taken until it is loaded there.
//  a push that ends a hop runs a frame: windowing, nine fft stages on the
//  working memory's single write port, then the power pass; no item is taken
//  during the frame. reset needs no clearing pass: a fill count masks
//  unwritten window slots and spectra read as zero until the first frame.
//  a result waits in out_data while the next transfer is taken.
// ----------------------------------------------------------------------------
module sliding_fft_two_axis_power (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sfp_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output sfp_pkg::out_item_t out_data
);
  import sfp_pkg::*;

  typedef enum logic [1:0] {T_IDLE, T_FRAME, T_DONE} top_state_t;

  top_state_t        st_r;
  logic [ADDR_W-1:0] wslot_r;
  logic [FILL_W-1:0] fill_r;
  logic [HOP_W-1:0]  hop_r;
  logic [CNT_W-1:0]  frames_r;
  logic              start_r;
  logic              spec_valid_r;
  logic              res_ready_r, res_read_r, res_rng_r;
  logic [BIN_W-1:0]  res_bin_r;
  logic              out_valid_r;
  out_item_t         out_data_r;
  out_item_t         res;

  logic              accept, is_push, hop_hit, out_free;

  sample_pair_t      win_mem [WINDOW_LEN];
  sample_pair_t      win_q_r;
  sample_pair_t      push_pair;
  spec_word_t        spec_mem [HALF_LEN];
  spec_word_t        spec_q_r;

  eng_req_t          eng_req;
  win_rd_t           win_rd;
  spec_wr_t          spec_wr;
  logic              eng_done;

  logic signed [ACC_W-1:0] xs, zs;

  assign in_stall  = (st_r != T_IDLE);
  assign accept    = in_valid && !in_stall;
  assign is_push   = (in_data.opcode == OP_PUSH);
  assign hop_hit   = (hop_r == HOP_W'(HOP_LEN - 1));
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // incoming samples clamped to the data path width
  always_comb begin
    xs = in_data.x_sample;
    zs = in_data.z_sample;
    push_pair.re = sat_d(xs);
    push_pair.im = sat_d(zs);
  end

  // sample window store
  always_ff @(posedge clk) begin
    if (accept && is_push) begin
      win_mem[wslot_r] <= push_pair;
    end
    if (win_rd.en) begin
      win_q_r <= win_mem[win_rd.addr];
    end
  end

  // spectrum store
  always_ff @(posedge clk) begin
    if (spec_wr.en) begin
      spec_mem[spec_wr.addr] <= spec_wr.data;
    end
    if (accept && !is_push) begin
      spec_q_r <= spec_mem[HALF_AW'(in_data.bin_index)];
    end
  end

  always_comb begin
    eng_req.start = start_r;
    eng_req.base  = wslot_r;
    eng_req.fill  = fill_r;
  end

  sfp_engine u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .eng_req  (eng_req),
    .win_rd   (win_rd),
    .win_q    (win_q_r),
    .spec_wr  (spec_wr),
    .eng_done (eng_done)
  );

  // result fields
  always_comb begin
    res.frame_ready = res_ready_r;
    res.frame_count = frames_r;
    res.read_bin    = res_bin_r;
    res.power_x     = '0;
    res.power_z     = '0;
    if (res_read_r && res_rng_r && spec_valid_r) begin
      res.power_x = spec_q_r.px;
      res.power_z = spec_q_r.pz;
    end
  end

  // control: window pointers, hop, frames and result transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= T_IDLE;
      wslot_r      <= '0;
      fill_r       <= '0;
      hop_r        <= '0;
      frames_r     <= '0;
      start_r      <= 1'b0;
      spec_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      start_r     <= 1'b0;
      // new result loads, a taken one clears, a stalled one stays
      out_valid_r <= ((st_r == T_DONE) && out_free) || (out_valid_r && out_stall);
      case (st_r)
        T_IDLE: begin
          if (accept) begin
            if (is_push) begin
              wslot_r <= wslot_r + 1'b1;
              if (fill_r != FILL_W'(WINDOW_LEN)) begin
                fill_r <= fill_r + 1'b1;
              end
              if (hop_hit) begin
                hop_r    <= '0;
                frames_r <= frames_r + 1'b1;
                start_r  <= 1'b1;
                st_r     <= T_FRAME;
              end else begin
                hop_r <= hop_r + 1'b1;
                st_r  <= T_DONE;
              end
            end else begin
              st_r <= T_DONE;
            end
          end
        end
        T_FRAME: begin
          if (eng_done) begin
            spec_valid_r <= 1'b1;
            st_r         <= T_DONE;
          end
        end
        T_DONE: begin
          if (out_free) begin
            st_r <= T_IDLE;
          end
        end
        default: st_r <= T_IDLE;
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      res_read_r  <= !is_push;
      res_ready_r <= is_push && hop_hit;
      res_bin_r   <= is_push ? '0 : in_data.bin_index;
      res_rng_r   <= (32'(in_data.bin_index) < 32'(HALF_LEN));
    end
    if (st_r == T_DONE && out_free) begin
      out_data_r <= res;
    end
  end

endmodule

[rtl/core/sfp_engine.sv]
// ----------------------------------------------------------------------------
// sfp_engine
// frame engine: windows the sample store into the fft working memory in
// bit-reversed order, runs the radix-2 stages through it with overlapped
// butterflies, then forms both power spectra into the spectrum store
// ----------------------------------------------------------------------------
module sfp_engine (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sfp_pkg::eng_req_t     eng_req,
  output sfp_pkg::win_rd_t      win_rd,
  input  sfp_pkg::sample_pair_t win_q,
  output sfp_pkg::spec_wr_t     spec_wr,
  output logic                  eng_done
);
  import sfp_pkg::*;

  typedef enum logic [1:0] {E_IDLE, E_LOAD, E_FFT, E_PWR} eng_state_t;

  eng_state_t        st_r;
  logic [ADDR_W-1:0] base_r;
  logic [FILL_W-1:0] fill_r;
  logic [ADDR_W:0]   cnt_r;
  logic [STG_W-1:0]  stg_r;
  logic              done_r;

  // working memory
  sample_pair_t      work_mem [WINDOW_LEN];
  sample_pair_t      rda_q_r, rdb_q_r;
  logic              rd_en;
  logic [ADDR_W-1:0] rda_addr, rdb_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  sample_pair_t      wr_data;

  // load pipeline
  logic              ld1_r, ld1_ok_r, ld2_r;
  logic [ADDR_W-1:0] ld1_dst_r, ld2_dst_r;
  logic [COEF_W-1:0] hann_q_r;
  logic signed [MUL_W-1:0] ld2_px_r, ld2_pz_r;

  // butterfly pipeline
  logic              f1_r, f2_r, f3_r, f4_r;
  logic [ADDR_W-1:0] f1_a_r, f1_b_r, f2_a_r, f2_b_r, f3_a_r, f3_b_r;
  logic signed [COEF_W-1:0] wc_r, ws_r;
  logic signed [D-1:0]      f2_ar_r, f2_ai_r;
  logic signed [MUL_W-1:0]  p0_r, p1_r, p2_r, p3_r;
  sample_pair_t      f3_na_r, f3_nb_r;

  // power pipeline
  logic               pw1_r, pw2_r;
  logic [HALF_AW-1:0] pw1_idx_r, pw2_idx_r;
  logic signed [SQ_W-1:0] q1_r, q2_r, q3_r, q4_r;

  // issue conditions
  logic ld_issue, ff_issue, pw_issue;
  logic issue_done;

  // butterfly addressing
  logic [HALF_AW-1:0] bf, mask, kk, ti;
  logic [ADDR_W-1:0]  one_sh, fa, fb;
  logic [STG_W-1:0]   shamt;

  // load datapath
  sample_pair_t      smp;
  logic signed [COEF_W:0] hann_s;

  // butterfly datapath
  logic signed [ACC_W-1:0] br, bi, tr, tim, ar, ai;
  sample_pair_t      na, nb;

  // power datapath
  logic signed [D:0] s1, s2, s3, s4;
  logic [SQ_W:0]     sx, sz;
  logic [SQ_W:0]     vx, vz;

  logic signed [ACC_W-1:0] lx, lz;

  assign issue_done = (cnt_r == (ADDR_W+1)'(HALF_LEN));
  assign ld_issue   = (st_r == E_LOAD) && (cnt_r != (ADDR_W+1)'(WINDOW_LEN));
  assign ff_issue   = (st_r == E_FFT) && !issue_done && !f1_r;
  assign pw_issue   = (st_r == E_PWR) && !issue_done;

  // butterfly addresses and twiddle index for the current stage
  always_comb begin
    bf     = cnt_r[HALF_AW-1:0];
    one_sh = ADDR_W'(1) << stg_r;
    mask   = HALF_AW'(one_sh - ADDR_W'(1));
    kk     = bf & mask;
    fa     = {bf & ~mask, 1'b0} | {1'b0, kk};
    fb     = fa | one_sh;
    shamt  = STG_W'(LOG2_LEN - 1) - stg_r;
    ti     = kk << shamt;
  end

  // memory port selection
  always_comb begin
    rd_en    = ff_issue || pw_issue;
    rda_addr = (st_r == E_FFT) ? fa : ADDR_W'(cnt_r[HALF_AW-1:0]);
    rdb_addr = (st_r == E_FFT) ? fb : ADDR_W'(-cnt_r[ADDR_W-1:0]);
    wr_en    = ld2_r || f3_r || f4_r;
    wr_addr  = ld2_dst_r;
    wr_data  = '0;
    if (f3_r) begin
      wr_addr = f3_a_r;
      wr_data = f3_na_r;
    end else if (f4_r) begin
      wr_addr = f3_b_r;
      wr_data = f3_nb_r;
    end else begin
      wr_data.re = sat_d(lx);
      wr_data.im = sat_d(lz);
    end
  end

  always_comb begin
    lx = rshr(ACC_W'(ld2_px_r), 15);
    lz = rshr(ACC_W'(ld2_pz_r), 15);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      work_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rda_q_r <= work_mem[rda_addr];
      rdb_q_r <= work_mem[rdb_addr];
    end
  end

  // sample fetch for the windowing pass
  always_comb begin
    win_rd.en   = ld_issue;
    win_rd.addr = base_r + cnt_r[ADDR_W-1:0];
  end

  // windowing multiply
  always_comb begin
    smp    = ld1_ok_r ? win_q : '0;
    hann_s = $signed({1'b0, hann_q_r});
  end

  // butterfly: twiddle products, then sums with halving
  always_comb begin
    br  = p0_r + p1_r;
    bi  = p2_r - p3_r;
    tr  = rshr(br, 15);
    tim = rshr(bi, 15);
    ar  = f2_ar_r;
    ai  = f2_ai_r;
    na.re = sat_d(rshr(ar + tr, 1));
    na.im = sat_d(rshr(ai + tim, 1));
    nb.re = sat_d(rshr(ar - tr, 1));
    nb.im = sat_d(rshr(ai - tim, 1));
  end

  // bin k and its mirror: sums and differences for both spectra
  always_comb begin
    s1 = rda_q_r.re + rdb_q_r.re;
    s2 = rda_q_r.im - rdb_q_r.im;
    s3 = rda_q_r.im + rdb_q_r.im;
    s4 = rdb_q_r.re - rda_q_r.re;
    sx = (SQ_W+1)'($unsigned(q1_r)) + (SQ_W+1)'($unsigned(q2_r)) + (SQ_W+1)'(2);
    sz = (SQ_W+1)'($unsigned(q3_r)) + (SQ_W+1)'($unsigned(q4_r)) + (SQ_W+1)'(2);
    vx = sx >> 2;
    vz = sz >> 2;
  end

  always_comb begin
    spec_wr.en   = pw2_r;
    spec_wr.addr = pw2_idx_r;
    spec_wr.data.px = (vx > (SQ_W+1)'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : vx[POW_W-1:0];
    spec_wr.data.pz = (vz > (SQ_W+1)'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : vz[POW_W-1:0];
  end

  assign eng_done = done_r;

  // sequencer and pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= E_IDLE;
      cnt_r  <= '0;
      stg_r  <= '0;
      done_r <= 1'b0;
      ld1_r  <= 1'b0;
      ld2_r  <= 1'b0;
      f1_r   <= 1'b0;
      f2_r   <= 1'b0;
      f3_r   <= 1'b0;
      f4_r   <= 1'b0;
      pw1_r  <= 1'b0;
      pw2_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      ld1_r  <= ld_issue;
      ld2_r  <= ld1_r;
      f1_r   <= ff_issue;
      f2_r   <= f1_r;
      f3_r   <= f2_r;
      f4_r   <= f3_r;
      pw1_r  <= pw_issue;
      pw2_r  <= pw1_r;
      case (st_r)
        E_IDLE: begin
          if (eng_req.start) begin
            st_r  <= E_LOAD;
            cnt_r <= '0;
          end
        end
        E_LOAD: begin
          if (ld_issue) begin
            cnt_r <= cnt_r + 1'b1;
          end else if (!ld1_r && !ld2_r) begin
            st_r  <= E_FFT;
            cnt_r <= '0;
            stg_r <= '0;
          end
        end
        E_FFT: begin
          if (ff_issue) begin
            cnt_r <= cnt_r + 1'b1;
          end else if (issue_done && !f1_r && !f2_r && !f3_r && !f4_r) begin
            cnt_r <= '0;
            if (stg_r == STG_W'(LOG2_LEN - 1)) begin
              st_r <= E_PWR;
            end else begin
              stg_r <= stg_r + 1'b1;
            end
          end
        end
        E_PWR: begin
          if (pw_issue) begin
            cnt_r <= cnt_r + 1'b1;
          end else if (!pw1_r && !pw2_r) begin
            st_r   <= E_IDLE;
            done_r <= 1'b1;
          end
        end
        default: st_r <= E_IDLE;
      endcase
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (eng_req.start) begin
      base_r <= eng_req.base;
      fill_r <= eng_req.fill;
    end
    // windowing pass
    if (ld_issue) begin
      ld1_ok_r  <= FILL_W'(win_rd.addr) < fill_r;
      ld1_dst_r <= bit_rev(cnt_r[ADDR_W-1:0]);
      hann_q_r  <= HANN_ROM[cnt_r[ADDR_W-1:0]];
    end
    ld2_dst_r <= ld1_dst_r;
    ld2_px_r  <= MUL_W'(smp.re * hann_s);
    ld2_pz_r  <= MUL_W'(smp.im * hann_s);
    // butterflies
    if (ff_issue) begin
      f1_a_r <= fa;
      f1_b_r <= fb;
      wc_r   <= TW_COS[ti];
      ws_r   <= TW_SIN[ti];
    end
    if (f1_r) begin
      f2_a_r  <= f1_a_r;
      f2_b_r  <= f1_b_r;
      f2_ar_r <= rda_q_r.re;
      f2_ai_r <= rda_q_r.im;
      p0_r    <= MUL_W'(rdb_q_r.re * wc_r);
      p1_r    <= MUL_W'(rdb_q_r.im * ws_r);
      p2_r    <= MUL_W'(rdb_q_r.im * wc_r);
      p3_r    <= MUL_W'(rdb_q_r.re * ws_r);
    end
    if (f2_r) begin
      f3_a_r  <= f2_a_r;
      f3_b_r  <= f2_b_r;
      f3_na_r <= na;
      f3_nb_r <= nb;
    end
    // power pass
    if (pw_issue) begin
      pw1_idx_r <= cnt_r[HALF_AW-1:0];
    end
    pw2_idx_r <= pw1_idx_r;
    q1_r <= SQ_W'(s1 * s1);
    q2_r <= SQ_W'(s2 * s2);
    q3_r <= SQ_W'(s3 * s3);
    q4_r <= SQ_W'(s4 * s4);
  end

endmodule

[bench/tb_sliding_fft_two_axis_power.sv]
// ----------------------------------------------------------------------------
// tb_sliding_fft_two_axis_power
// self-checking bench for the two-axis sliding spectrum engine: a directed
// table of pushes and reads, then random traffic with random gaps and stalls
// on both channels, each result checked against its table row or against a
// bit-exact spectrum predictor
`timescale 1ns / 1ps

module tb_sliding_fft_two_axis_power;
  import sfp_pkg::*;

  localparam int N_RANDOM   = 480;
  localparam int IDLE_LIMIT = 40000;
  localparam int HOLD_LEN   = 600;
  localparam int HOLD_AT    = 100;
  localparam longint Q30_ONE = 64'h4000_0000;
  localparam longint unsigned PI_Q30_TB = 64'hC90F_DAA2;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  sliding_fft_two_axis_power u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // predictor state
  longint    hann_coef [WINDOW_LEN];
  longint    cos_q15 [HALF_LEN];
  longint    sin_q15 [HALF_LEN];
  longint    samp_x [WINDOW_LEN];
  longint    samp_z [WINDOW_LEN];
  int        oldest_slot;
  int        pushes_in_hop;
  bit [31:0] bin_pow_x [HALF_LEN];
  bit [31:0] bin_pow_z [HALF_LEN];
  bit [15:0] frames_seen;

  out_item_t pending_bins[$];
  bit        failed;
  int        results_seen;
  int        idle_cycles;

  // floor((v + 2^(s-1)) / 2^s)
  function automatic longint round_half_up(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clamp_d(longint v);
    longint hi;
    hi = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // q30 series, angle up to an eighth of a turn
  task automatic series_q30(input longint unsigned a, output longint unsigned c,
                            output longint unsigned s);
    longint unsigned a2, t, r;
    a2 = (a * a) >> 30;
    t = a; r = a;
    t = ((t * a2) >> 30) / 6;  r = r - t;
    t = ((t * a2) >> 30) / 20; r = r + t;
    t = ((t * a2) >> 30) / 42; r = r - t;
    t = ((t * a2) >> 30) / 72; r = r + t;
    s = r;
    t = Q30_ONE; r = t;
    t = ((t * a2) >> 30) / 2;  r = r - t;
    t = ((t * a2) >> 30) / 12; r = r + t;
    t = ((t * a2) >> 30) / 30; r = r - t;
    t = ((t * a2) >> 30) / 56; r = r + t;
    c = r;
  endtask

  // cos and sin of a q32 fraction of a turn
  task automatic turn_trig(input bit [31:0] p, output longint c, output longint s);
    longint unsigned f, a, b, c0, s0;
    f = p[29:0];
    if (f <= 64'h2000_0000) begin
      series_q30((f * PI_Q30_TB) >> 31, a, b);
      c0 = a; s0 = b;
    end else begin
      series_q30(((64'h4000_0000 - f) * PI_Q30_TB) >> 31, a, b);
      c0 = b; s0 = a;
    end
    case (p[31:30])
      2'd0:    begin c = c0;  s = s0;  end
      2'd1:    begin c = -s0; s = c0;  end
      2'd2:    begin c = -c0; s = -s0; end
      default: begin c = s0;  s = -c0; end
    endcase
  endtask

  task automatic spectrum_reset();
    longint c, s;
    longint unsigned num;
    for (int i = 0; i < WINDOW_LEN; i++) begin
      num = longint'(i) << 32;
      turn_trig(32'(num / (WINDOW_LEN - 1)), c, s);
      hann_coef[i] = (Q30_ONE - c + 32768) >>> 16;
      samp_x[i] = 0;
      samp_z[i] = 0;
    end
    for (int i = 0; i < HALF_LEN; i++) begin
      turn_trig(32'((longint'(i) << 32) >> LOG2_LEN), c, s);
      cos_q15[i] = round_half_up(c, 15);
      sin_q15[i] = round_half_up(s, 15);
      bin_pow_x[i] = '0;
      bin_pow_z[i] = '0;
    end
    oldest_slot = 0;
    pushes_in_hop = 0;
    frames_seen = '0;
  endtask

  function automatic bit [31:0] power_sat(longint a, longint b);
    longint unsigned p;
    p = (longint'(a * a) + longint'(b * b) + 2) >> 2;
    return (p > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : p[31:0];
  endfunction

  // windowed fft over the whole window, oldest sample first
  task automatic run_spectrum();
    longint wr [WINDOW_LEN];
    longint wi [WINDOW_LEN];
    int slot, rev, ti, half, step;
    longint tr, tim, ar, ai, wc, ws, br, bi, ra, ia, rb, ib;
    for (int i = 0; i < WINDOW_LEN; i++) begin
      slot = (oldest_slot + i) % WINDOW_LEN;
      rev = 0;
      for (int k = 0; k < LOG2_LEN; k++) rev = (rev << 1) | ((i >> k) & 1);
      wr[rev] = clamp_d(round_half_up(samp_x[slot] * hann_coef[i], 15));
      wi[rev] = clamp_d(round_half_up(samp_z[slot] * hann_coef[i], 15));
    end
    for (int m = 2; m <= WINDOW_LEN; m = m << 1) begin
      half = m >> 1;
      step = WINDOW_LEN / m;
      for (int g = 0; g < WINDOW_LEN; g += m) begin
        for (int k = 0; k < half; k++) begin
          ti = (k * step) % HALF_LEN;
          wc = cos_q15[ti]; ws = sin_q15[ti];
          br = wr[g+k+half]; bi = wi[g+k+half];
          tr  = round_half_up(br * wc + bi * ws, 15);
          tim = round_half_up(bi * wc - br * ws, 15);
          ar = wr[g+k]; ai = wi[g+k];
          wr[g+k] = clamp_d(round_half_up(ar + tr, 1));
          wi[g+k] = clamp_d(round_half_up(ai + tim, 1));
          wr[g+k+half] = clamp_d(round_half_up(ar - tr, 1));
          wi[g+k+half] = clamp_d(round_half_up(ai - tim, 1));
        end
      end
    end
    // split the two real spectra from bins k and N-k
    for (int i = 0; i < HALF_LEN; i++) begin
      slot = (i == 0) ? 0 : WINDOW_LEN - i;
      ra = wr[i]; ia = wi[i]; rb = wr[slot]; ib = wi[slot];
      bin_pow_x[i] = power_sat(ra + rb, ia - ib);
      bin_pow_z[i] = power_sat(ia + ib, rb - ra);
    end
  endtask

  task automatic spectrum_predict(input in_item_t it, output out_item_t r);
    r = '0;
    if (it.opcode == OP_PUSH) begin
      samp_x[oldest_slot] = clamp_d(longint'(it.x_sample));
      samp_z[oldest_slot] = clamp_d(longint'(it.z_sample));
      oldest_slot = (oldest_slot + 1) % WINDOW_LEN;
      pushes_in_hop++;
      if (pushes_in_hop >= HOP_LEN) begin
        pushes_in_hop = 0;
        frames_seen = frames_seen + 16'd1;
        run_spectrum();
        r.frame_ready = 1'b1;
      end
    end else begin
      r.read_bin = it.bin_index;
      if (it.bin_index < HALF_LEN) begin
        r.power_x = bin_pow_x[it.bin_index];
        r.power_z = bin_pow_z[it.bin_index];
      end
    end
    r.frame_count = frames_seen;
  endtask

  // offer one item after a random gap, hold it until the transfer
  task automatic send_item(input in_item_t it, input bit typed, input out_item_t typed_res);
    int gap;
    out_item_t r;
    gap = $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    spectrum_predict(it, r);
    pending_bins.push_back(typed ? typed_res : r);
  endtask

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // directed rows
  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t res;
  } stim_row_t;

  stim_row_t dir_rows [12];

  initial begin
    in_item_t it;
    // reads after reset see empty spectra
    dir_rows[0]  = '{'{OP_READ, 16'sh0000, 16'sh0000, 8'd0},   1'b1, '{0, 0, 8'd0, 0, 0}};
    dir_rows[1]  = '{'{OP_READ, 16'sh7FFF, 16'sh8000, 8'd255}, 1'b1, '{0, 0, 8'd255, 0, 0}};
    dir_rows[2]  = '{'{OP_READ, 16'sh8000, 16'sh7FFF, 8'd128}, 1'b1, '{0, 0, 8'd128, 0, 0}};
    // pushes at the sample extremes and near zero, bin ignored
    dir_rows[3]  = '{'{OP_PUSH, 16'sh7FFF, 16'sh8000, 8'd255}, 1'b1, '0};
    dir_rows[4]  = '{'{OP_PUSH, 16'sh8000, 16'sh7FFF, 8'd0},   1'b1, '0};
    dir_rows[5]  = '{'{OP_PUSH, 16'sh0000, 16'sh0000, 8'hAA},  1'b1, '0};
    dir_rows[6]  = '{'{OP_PUSH, 16'shFFFF, 16'sh0001, 8'h55},  1'b1, '0};
    dir_rows[7]  = '{'{OP_PUSH, 16'sh7FFF, 16'sh7FFF, 8'd1},   1'b0, '0};
    dir_rows[8]  = '{'{OP_PUSH, 16'sh8000, 16'sh8000, 8'd2},   1'b0, '0};
    dir_rows[9]  = '{'{OP_READ, 16'sh0000, 16'sh0000, 8'd1},   1'b1, '{0, 0, 8'd1, 0, 0}};
    dir_rows[10] = '{'{OP_READ, 16'shFFFF, 16'shFFFF, 8'd127}, 1'b0, '0};
    dir_rows[11] = '{'{OP_PUSH, 16'sh5555, 16'shAAAA, 8'd3},   1'b0, '0};

    spectrum_reset();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].res);

    // random traffic, mostly pushes so frames keep coming
    for (int n = 0; n < N_RANDOM; n++) begin
      it.opcode    = ($urandom_range(0, 3) == 0) ? OP_READ : OP_PUSH;
      it.x_sample  = pick_sample();
      it.z_sample  = pick_sample();
      it.bin_index = 8'($urandom);
      send_item(it, 1'b0, '0);
    end
    in_valid <= 1'b0;

    // drain, then allow the result path to settle
    wait (pending_bins.size() == 0);
    repeat (50) @(posedge clk);
    if (!failed) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // receiver: random stall per result, one long hold to back up the block
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      n = (results_seen == HOLD_AT) ? HOLD_LEN : $urandom_range(0, 10);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // result check against the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      if (pending_bins.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_data);
        failed = 1'b1;
      end else begin
        want = pending_bins.pop_front();
        if (out_data.frame_ready !== want.frame_ready) begin
          $display("%0t: frame_ready exp %0d got %0d", $time, want.frame_ready,
                   out_data.frame_ready);
          failed = 1'b1;
        end
        if (out_data.frame_count !== want.frame_count) begin
          $display("%0t: frame_count exp %0d got %0d", $time, want.frame_count,
                   out_data.frame_count);
          failed = 1'b1;
        end
        if (out_data.read_bin !== want.read_bin) begin
          $display("%0t: read_bin exp %0d got %0d", $time, want.read_bin, out_data.read_bin);
          failed = 1'b1;
        end
        if (out_data.power_x !== want.power_x) begin
          $display("%0t: power_x exp %0d got %0d", $time, want.power_x, out_data.power_x);
          failed = 1'b1;
        end
        if (out_data.power_z !== want.power_z) begin
          $display("%0t: power_z exp %0d got %0d", $time, want.power_z, out_data.power_z);
          failed = 1'b1;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule

[files.f]
rtl/core/sfp_pkg.sv
rtl/core/sfp_engine.sv
rtl/core/sliding_fft_two_axis_power.sv
bench/tb_sliding_fft_two_axis_power.sv
